// ===== hw/rtl/lsq_pkg.sv =====
// shared types and constants for the load/store queue
// no dependencies
package lsq_pkg;

	localparam int KIND_W = 6;
	localparam int WORD_W = 32;

	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic signed [WORD_W-1:0] word_t;

	// opcode of an input word
	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// address held by a freshly inserted entry
	localparam word_t ADDR_UNSET = '1;

	// update broadcast to every cell
	typedef struct packed {
		logic  apply;
		logic  ins_en;
		kind_t ins_kind;
		word_t ins_tag;
		logic  alu_valid;
		word_t alu_rob;
		word_t alu_result;
		logic  st_valid;
		word_t st_rob;
		word_t st_address;
		word_t st_value;
	} lsq_upd_t;

endpackage

// ===== hw/rtl/lsq_cell.sv =====
// one queue slot: entry storage, tag match and a link of the flush probe chain
// depends on lsq_pkg
module lsq_cell #(
	parameter int PTR_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [PTR_W-1:0] idx,
	input  logic [PTR_W-1:0] head,
	input  logic [PTR_W-1:0] tail_ins,
	input  logic [PTR_W-1:0] tail_new,
	input  lsq_pkg::lsq_upd_t upd,
	input  logic             probe_load,
	input  logic             probe_step,
	input  logic             probe_in,
	output logic             probe_out,
	output lsq_pkg::kind_t   kind,
	output lsq_pkg::word_t   addr,
	output lsq_pkg::word_t   tag,
	output logic             ready,
	output logic             hit
);
	import lsq_pkg::*;

	kind_t kind_q;
	word_t addr_q;
	word_t tag_q;
	logic  ready_q;
	logic  probe_q;

	logic  ins_here;
	logic  live;
	logic  alu_hit;
	logic  st_hit;
	kind_t kind_d;
	word_t addr_d;
	word_t tag_d;
	logic  ready_d;
	logic  ready_mid;

	always_comb begin
		ins_here = upd.ins_en && (idx == tail_ins);
		if (head <= tail_new) begin
			live = (idx >= head) && (idx < tail_new);
		end else begin
			live = (idx >= head) || (idx < tail_new);
		end

		kind_d  = ins_here ? upd.ins_kind : kind_q;
		addr_d  = ins_here ? ADDR_UNSET : addr_q;
		tag_d   = ins_here ? upd.ins_tag : tag_q;
		ready_d = ins_here ? 1'b0 : ready_q;

		// alu match first, then store match on what is left
		alu_hit = upd.alu_valid && live && !ready_d && (tag_d == upd.alu_rob);
		if (alu_hit) begin
			addr_d = upd.alu_result;
		end
		ready_mid = ready_d || alu_hit;

		st_hit = upd.st_valid && live && !ready_mid && (tag_d == upd.st_rob);
		if (st_hit) begin
			addr_d = upd.st_address;
			tag_d  = upd.st_value;
		end
		ready_d = ready_mid || st_hit;
	end

	always_ff @(posedge clk) begin
		if (upd.apply) begin
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			tag_q   <= tag_d;
			ready_q <= ready_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= 1'b0;
		end else if (probe_load) begin
			probe_q <= (idx == head);
		end else if (probe_step) begin
			probe_q <= probe_in;
		end
	end

	assign probe_out = probe_q;
	assign kind      = kind_q;
	assign addr      = addr_q;
	assign tag       = tag_q;
	assign ready     = ready_q;
	assign hit       = probe_q && !ready_q;

endmodule

// ===== hw/rtl/load_store_queue_issue.sv =====
// Circular load/store queue built as a ring of slot cells. An update word is accepted,
// then applied to every cell in parallel; with flush set it first walks a probe from
// the head along the ring, one slot per cycle, until it meets an entry that is not
// ready or reaches the tail. An advance word is accepted, then acted on at the head.
// One word is worked on at a time; each gives exactly one result word, held in an
// output register so the next input word is taken while it waits.
// top level; depends on lsq_pkg and lsq_cell
module load_store_queue_issue #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ISSUE_DELAY = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic                  flush,
	input  logic                  dec_valid,
	input  lsq_pkg::kind_t        dec_kind,
	input  lsq_pkg::word_t        rob_tail_tag,
	input  logic                  alu_valid,
	input  lsq_pkg::word_t        alu_rob,
	input  lsq_pkg::word_t        alu_result,
	input  logic                  st_valid,
	input  lsq_pkg::word_t        st_rob,
	input  lsq_pkg::word_t        st_address,
	input  lsq_pkg::word_t        st_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  issue_valid,
	output lsq_pkg::kind_t        issue_kind,
	output lsq_pkg::word_t        issue_address,
	output lsq_pkg::word_t        issue_tag
);
	import lsq_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int WAIT_W = $clog2(ISSUE_DELAY + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY, ST_ADV} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] scan_q;
	logic [WAIT_W-1:0] wait_q;
	lsq_upd_t         cap_q;
	logic             out_valid_q;
	logic             issue_valid_q;
	kind_t            issue_kind_q;
	word_t            issue_address_q;
	word_t            issue_tag_q;

	lsq_upd_t         upd;
	logic [PTR_W-1:0] tail_new;
	logic [WAIT_W-1:0] wait_inc;
	logic             accept;
	logic             slot_free;
	logic             result_load;
	logic             probe_load;
	logic             probe_step;
	logic             at_tail;
	logic             hit_any;
	logic             scan_done;

	kind_t kind_arr  [QUEUE_DEPTH];
	word_t addr_arr  [QUEUE_DEPTH];
	word_t tag_arr   [QUEUE_DEPTH];
	logic  ready_vec [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] probe_vec;
	logic [QUEUE_DEPTH-1:0] hit_vec;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign result_load = ((state_q == ST_APPLY) || (state_q == ST_ADV)) && slot_free;
	assign probe_load  = accept && (opcode == OP_UPDATE) && flush;
	assign at_tail     = (scan_q == tail_q);
	assign hit_any     = |hit_vec;
	assign scan_done   = at_tail || hit_any;
	assign probe_step  = (state_q == ST_SCAN) && !scan_done;
	assign tail_new    = cap_q.ins_en ? next_slot(tail_q) : tail_q;
	assign wait_inc    = wait_q + WAIT_W'(1);

	always_comb begin
		upd       = cap_q;
		upd.apply = (state_q == ST_APPLY) && slot_free;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		lsq_cell #(
			.PTR_W(PTR_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (PTR_W'(i)),
			.head      (head_q),
			.tail_ins  (tail_q),
			.tail_new  (tail_new),
			.upd       (upd),
			.probe_load(probe_load),
			.probe_step(probe_step),
			.probe_in  (probe_vec[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
			.probe_out (probe_vec[i]),
			.kind      (kind_arr[i]),
			.addr      (addr_arr[i]),
			.tag       (tag_arr[i]),
			.ready     (ready_vec[i]),
			.hit       (hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			head_q          <= '0;
			tail_q          <= '0;
			scan_q          <= '0;
			wait_q          <= '0;
			cap_q           <= '0;
			out_valid_q     <= 1'b0;
			issue_valid_q   <= 1'b0;
			issue_kind_q    <= '0;
			issue_address_q <= '0;
			issue_tag_q     <= '0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cap_q.apply      <= 1'b0;
						cap_q.ins_en     <= dec_valid;
						cap_q.ins_kind   <= dec_kind;
						cap_q.ins_tag    <= rob_tail_tag;
						cap_q.alu_valid  <= alu_valid;
						cap_q.alu_rob    <= alu_rob;
						cap_q.alu_result <= alu_result;
						cap_q.st_valid   <= st_valid;
						cap_q.st_rob     <= st_rob;
						cap_q.st_address <= st_address;
						cap_q.st_value   <= st_value;
						scan_q           <= head_q;
						if (opcode == OP_ADVANCE) begin
							state_q <= ST_ADV;
						end else if (flush) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (!at_tail) begin
							tail_q <= scan_q;
						end
						state_q <= ST_APPLY;
					end else begin
						scan_q <= next_slot(scan_q);
					end
				end
				ST_APPLY: begin
					if (slot_free) begin
						tail_q <= tail_new;
						if (cap_q.ins_en && (tail_q == head_q)) begin
							wait_q <= '0;
						end
						issue_valid_q   <= 1'b0;
						issue_kind_q    <= '0;
						issue_address_q <= '0;
						issue_tag_q     <= '0;
						state_q         <= ST_IDLE;
					end
				end
				ST_ADV: begin
					if (slot_free) begin
						if ((head_q != tail_q) && ready_vec[head_q]
								&& (wait_inc >= WAIT_W'(ISSUE_DELAY))) begin
							issue_valid_q   <= 1'b1;
							issue_kind_q    <= kind_arr[head_q];
							issue_address_q <= addr_arr[head_q];
							issue_tag_q     <= tag_arr[head_q];
							wait_q          <= '0;
							head_q          <= next_slot(head_q);
						end else begin
							issue_valid_q   <= 1'b0;
							issue_kind_q    <= '0;
							issue_address_q <= '0;
							issue_tag_q     <= '0;
							if ((head_q != tail_q) && ready_vec[head_q]) begin
								wait_q <= wait_inc;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign issue_valid   = issue_valid_q;
	assign issue_kind    = issue_kind_q;
	assign issue_address = issue_address_q;
	assign issue_tag     = issue_tag_q;

endmodule

// ===== hw/rtl/lsq_checker.sv =====
// port-level checks for the load/store queue, bound to the top level
// depends on lsq_pkg and load_store_queue_issue
module lsq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic           issue_valid,
	input lsq_pkg::kind_t issue_kind,
	input lsq_pkg::word_t issue_address,
	input lsq_pkg::word_t issue_tag
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(issue_valid)
			&& $stable(issue_kind) && $stable(issue_address) && $stable(issue_tag))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// a new result only follows work on an accepted word
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result word appeared without an accepted input");

	// no issue means empty fields
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !issue_valid |-> (issue_kind == '0) && (issue_address == '0)
			&& (issue_tag == '0))
		else $error("fields set on a result word with no issue");

endmodule

bind load_store_queue_issue lsq_checker u_lsq_checker (.*);
